FILE: rtl/seven_segment_frame_receiver_core_macros.svh
// Assertion macros shared by the frame receiver RTL.
`ifndef SEVEN_SEGMENT_FRAME_RECEIVER_CORE_MACROS_SVH
`define SEVEN_SEGMENT_FRAME_RECEIVER_CORE_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define SSFR_ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SSFR_ASSERT_SAME(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SSFR_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/ssfr_pkg.sv
// Types and constants of the seven-segment frame receiver.
package ssfr_pkg;

	localparam logic [7:0] START_BYTE  = 8'h9B;
	localparam logic [7:0] END_BYTE    = 8'h9D;
	localparam logic [7:0] KIND_HEIGHT = 8'h12;
	localparam logic [7:0] KIND_POLL   = 8'h11;
	localparam logic [7:0] LEN_CEILING = 8'd253;

	localparam int unsigned HEIGHT_W = 14;

	localparam logic [1:0] REG_LO_TENTHS  = 2'd0;
	localparam logic [1:0] REG_HI_TENTHS  = 2'd1;
	localparam logic [1:0] REG_MAX_LENGTH = 2'd2;

	localparam logic [HEIGHT_W-1:0] LO_TENTHS_RST  = 14'd0;
	localparam logic [HEIGHT_W-1:0] HI_TENTHS_RST  = 14'd9990;
	localparam logic [7:0]          MAX_LENGTH_RST = 8'd30;

	typedef enum logic [3:0] {
		EV_HEIGHT      = 4'd0,
		EV_POLL        = 4'd1,
		EV_BLANK       = 4'd2,
		EV_DASH        = 4'd3,
		EV_BAD_PATTERN = 4'd4,
		EV_ZERO        = 4'd5,
		EV_RANGE       = 4'd6,
		EV_BAD_END     = 4'd7,
		EV_TOO_LONG    = 4'd8,
		EV_OTHER       = 4'd9
	} event_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0] lo_tenths;
		logic [HEIGHT_W-1:0] hi_tenths;
		logic [7:0]          max_length;
	} cfg_t;

	typedef struct packed {
		event_t              ev;
		logic [HEIGHT_W-1:0] height;
		logic                changed;
	} res_t;

endpackage

FILE: rtl/ssfr_parse.sv
// Frame parser: byte counting, digit decode, height check and stored height.
module ssfr_parse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    rx_byte,
	input  ssfr_pkg::cfg_t cfg,
	output logic          res_valid,
	output ssfr_pkg::res_t res
);

	localparam logic [3:0] DIG_BLANK   = 4'd10;
	localparam logic [3:0] DIG_DASH    = 4'd11;
	localparam logic [3:0] DIG_UNKNOWN = 4'd12;

	function automatic logic [3:0] seg_decode(input logic [6:0] seg);
		logic [3:0] d;
		unique case (seg)
			7'h00:   d = DIG_BLANK;
			7'h40:   d = DIG_DASH;
			7'h3F:   d = 4'd0;
			7'h06:   d = 4'd1;
			7'h5B:   d = 4'd2;
			7'h4F:   d = 4'd3;
			7'h66:   d = 4'd4;
			7'h6D:   d = 4'd5;
			7'h7D:   d = 4'd6;
			7'h07:   d = 4'd7;
			7'h7F:   d = 4'd8;
			7'h6F:   d = 4'd9;
			default: d = DIG_UNKNOWN;
		endcase
		return d;
	endfunction

	logic [7:0]  count_q;
	logic [7:0]  end_q;
	logic        kind_h_q;
	logic        kind_p_q;
	logic        len_ok_q;
	logic [3:0]  dig_q [3];
	logic        dp2_q;
	logic [ssfr_pkg::HEIGHT_W-1:0] last_q;

	logic [7:0]  limit;
	logic [7:0]  cnt_inc;
	logic [8:0]  len_plus2;
	logic        kind_h;
	logic        kind_p;
	logic        at_end;
	logic        too_long;
	logic [7:0]  count_d;
	logic [3:0]  d1;
	logic        any_dash;
	logic        any_bad;
	logic [9:0]  raw;
	logic [ssfr_pkg::HEIGHT_W-1:0] h;
	ssfr_pkg::res_t hres;

	assign limit    = (cfg.max_length > ssfr_pkg::LEN_CEILING) ? ssfr_pkg::LEN_CEILING
		: cfg.max_length;
	assign cnt_inc  = count_q + 8'd1;
	assign len_plus2 = {1'b0, rx_byte} + 9'd2;
	assign too_long = (count_q == 8'd1) && (rx_byte > limit);
	// a short frame ends on its type byte, so take the kind from the live byte
	assign kind_h   = (count_q == 8'd2) ? (rx_byte == ssfr_pkg::KIND_HEIGHT) : kind_h_q;
	assign kind_p   = (count_q == 8'd2) ? (rx_byte == ssfr_pkg::KIND_POLL) : kind_p_q;
	assign at_end   = (count_q >= 8'd2) && (cnt_inc >= end_q);

	// height evaluation from the decoded digits
	assign d1       = (dig_q[0] == DIG_BLANK) ? 4'd0 : dig_q[0];
	assign any_dash = (d1 == DIG_DASH) || (dig_q[1] == DIG_DASH) || (dig_q[2] == DIG_DASH);
	assign any_bad  = (d1 > 4'd9) || (dig_q[1] > 4'd9) || (dig_q[2] > 4'd9);
	assign raw      = {6'd0, d1} * 10'd100 + {6'd0, dig_q[1]} * 10'd10 + {6'd0, dig_q[2]};
	assign h        = dp2_q ? {4'd0, raw} : {4'd0, raw} * 14'd10;

	always_comb begin
		hres = '{ev: ssfr_pkg::EV_HEIGHT, height: '0, changed: 1'b0};
		if ((dig_q[0] == DIG_BLANK) && (dig_q[1] == DIG_BLANK) && (dig_q[2] == DIG_BLANK)) begin
			hres.ev = ssfr_pkg::EV_BLANK;
		end else if (any_dash) begin
			hres.ev = ssfr_pkg::EV_DASH;
		end else if (any_bad) begin
			hres.ev = ssfr_pkg::EV_BAD_PATTERN;
		end else if (raw == 10'd0) begin
			hres.ev = ssfr_pkg::EV_ZERO;
		end else if ((h < cfg.lo_tenths) || (h > cfg.hi_tenths)) begin
			hres.ev = ssfr_pkg::EV_RANGE;
		end else begin
			hres.height  = h;
			hres.changed = (h != last_q);
		end
	end

	always_comb begin
		res_valid = 1'b0;
		res       = '{ev: ssfr_pkg::EV_OTHER, height: '0, changed: 1'b0};
		if (too_long) begin
			res_valid = 1'b1;
			res.ev    = ssfr_pkg::EV_TOO_LONG;
		end else if (at_end) begin
			res_valid = 1'b1;
			if (rx_byte != ssfr_pkg::END_BYTE) begin
				res.ev = ssfr_pkg::EV_BAD_END;
			end else if (kind_h && len_ok_q) begin
				res = hres;
			end else if (kind_p) begin
				res.ev = ssfr_pkg::EV_POLL;
			end
		end
	end

	always_comb begin
		if (count_q == 8'd0) begin
			count_d = (rx_byte == ssfr_pkg::START_BYTE) ? 8'd1 : 8'd0;
		end else if (count_q == 8'd1) begin
			count_d = too_long ? 8'd0 : 8'd2;
		end else begin
			count_d = at_end ? 8'd0 : cnt_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 8'd0;
			last_q  <= '0;
		end else if (step) begin
			count_q <= count_d;
			if (res_valid && (res.ev == ssfr_pkg::EV_HEIGHT)) begin
				last_q <= res.height;
			end
		end
	end

	// frame fields, each written by the frame before it is read
	always_ff @(posedge clk) begin
		if (step) begin
			if ((count_q == 8'd1) && !too_long) begin
				end_q    <= (len_plus2 < 9'd3) ? 8'd3 : len_plus2[7:0];
				len_ok_q <= (rx_byte == 8'd7) || (rx_byte == 8'd10);
			end
			if (count_q == 8'd2) begin
				kind_h_q <= kind_h;
				kind_p_q <= kind_p;
			end
			case (count_q)
				8'd3: dig_q[0] <= seg_decode(rx_byte[6:0]);
				8'd4: begin
					dig_q[1] <= seg_decode(rx_byte[6:0]);
					dp2_q    <= rx_byte[7];
				end
				8'd5: dig_q[2] <= seg_decode(rx_byte[6:0]);
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/seven_segment_frame_receiver_core.sv
// Seven-segment frame receiver: input stage, config registers, parser and output queue.
//
// One received byte per beat, one beat per cycle sustained. A byte is held in the input
// register, is parsed there against the frame state, and a resulting event is registered
// into a two-entry output queue, so out_valid rises once the byte that closes the frame
// has passed the input register and been pushed into the queue. The input stage stalls
// only while both queue entries are full. Configuration writes take effect at once and
// are always ready.
module seven_segment_frame_receiver_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  event_res,
	output logic [13:0] height_tenths,
	output logic        height_changed,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data
);

	`include "seven_segment_frame_receiver_core_macros.svh"

	ssfr_pkg::cfg_t cfg_q;
	logic           v_s1;
	logic [7:0]     byte_s1;
	logic           adv;
	logic           res_valid;
	ssfr_pkg::res_t res;
	ssfr_pkg::res_t out0_q;
	ssfr_pkg::res_t out1_q;
	logic [1:0]     cnt_q;
	logic           pop;
	logic           push;
	logic [1:0]     cnt_after_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lo_tenths  <= ssfr_pkg::LO_TENTHS_RST;
			cfg_q.hi_tenths  <= ssfr_pkg::HI_TENTHS_RST;
			cfg_q.max_length <= ssfr_pkg::MAX_LENGTH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ssfr_pkg::REG_LO_TENTHS:  cfg_q.lo_tenths  <= cfg_data;
				ssfr_pkg::REG_HI_TENTHS:  cfg_q.hi_tenths  <= cfg_data;
				ssfr_pkg::REG_MAX_LENGTH: cfg_q.max_length <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// advance the input stage unless the output queue is full
	assign adv      = v_s1 && (cnt_q != 2'd2);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	ssfr_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.rx_byte   (byte_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	assign pop           = (cnt_q != 2'd0) && out_ready;
	assign push          = adv && res_valid;
	assign cnt_after_pop = cnt_q - {1'b0, pop};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_after_pop + {1'b0, push};
		end
	end

	// drop the new result in the free slot, else shift the tail forward on a beat out
	always_ff @(posedge clk) begin
		if (push && (cnt_after_pop == 2'd0)) begin
			out0_q <= res;
		end else if (pop) begin
			out0_q <= out1_q;
		end
		if (push && (cnt_after_pop != 2'd0)) begin
			out1_q <= res;
		end
	end

	assign out_valid      = (cnt_q != 2'd0);
	assign event_res      = out0_q.ev;
	assign height_tenths  = out0_q.height;
	assign height_changed = out0_q.changed;

	`SSFR_ASSERT_ALWAYS(a_cnt_bound, cnt_q != 2'd3, "output queue count out of range")
	`SSFR_ASSERT_SAME(a_stall_full, v_s1 && !in_ready, cnt_q == 2'd2, "input stalled with queue space")
	`SSFR_ASSERT_NEXT(a_push_show, push && (cnt_q == 2'd0), out_valid && (event_res == $past(res.ev)), "pushed result not shown")
	`SSFR_ASSERT_SAME(a_non_height_clear, out_valid && (event_res != ssfr_pkg::EV_HEIGHT), (height_tenths == 14'd0) && !height_changed, "height fields set on non-height event")

endmodule
